// ===== rtl/core/clamped_linear_interp_table_macros.svh =====
// ----------------------------------------------------------------------------
// clamped_linear_interp_table_macros.svh
// Assertion shorthands shared by the interpolation table RTL.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_LINEAR_INTERP_TABLE_MACROS_SVH
`define CLAMPED_LINEAR_INTERP_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CLIT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define CLIT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/clit_pkg.sv =====
// ----------------------------------------------------------------------------
// clit_pkg
// Types, codes and widths shared by the interpolation table controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package clit_pkg;

   localparam int CLIT_MAX_POINTS_DEF = 64;

   localparam int VAL_W       = 17;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int ACT_W       = 2;
   localparam int STAT_W      = 2;
   localparam int REQ_TDATA_W = ((3 * VAL_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((2 * VAL_W + 7) / 8) * 8;
   localparam int DIV_STEPS   = VAL_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [VAL_W-1:0] abscissa;
      logic [VAL_W-1:0] water;
      logic [VAL_W-1:0] oil;
   } entry_type;

   typedef enum logic [1:0] {
      RD_HEAD   = 2'd0,
      RD_TAIL   = 2'd1,
      RD_SECOND = 2'd2,
      RD_FOLLOW = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_HOLD = 2'd0,
      RES_PREV = 2'd1,
      RES_RD   = 2'd2,
      RES_LERP = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic        accept;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        save_prev;
      res_sel_type res_sel;
      logic        start_interp;
      logic        mul;
      logic        div_step;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic query_go;
      logic x_le_rd;
      logic x_ge_rd;
      logic in_span;
      logic zero_span;
      logic idx_last;
      logic div_last;
   } stat_type;

endpackage

// ===== rtl/core/clit_ctrl.sv =====
// ----------------------------------------------------------------------------
// clit_ctrl
// Sequencer for the interpolation table: accepts words, walks the stored
// points, runs the lerp datapath and hands results to the output register.
// ----------------------------------------------------------------------------
module clit_ctrl
   import clit_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_FIRST = 8'b0000_0010,
      S_LAST  = 8'b0000_0100,
      S_SCAN  = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_DIV   = 8'b0010_0000,
      S_FIN   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.rd_sel       = RD_HEAD;
      cmd.res_sel      = RES_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (st.query_go) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_HEAD;
                  state_in   = S_FIRST;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FIRST: begin
            cmd.save_prev = 1'b1;
            if (st.x_le_rd) begin
               cmd.res_sel = RES_RD;
               state_in    = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_TAIL;
               state_in   = S_LAST;
            end
         end
         S_LAST: begin
            if (st.x_ge_rd) begin
               cmd.res_sel = RES_RD;
               state_in    = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SECOND;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (st.in_span) begin
               if (st.zero_span) begin
                  cmd.res_sel = RES_PREV;
                  state_in    = S_DONE;
               end else begin
                  cmd.start_interp = 1'b1;
                  state_in         = S_MUL;
               end
            end else if (st.idx_last) begin
               // no interval matched: fall back to the last point
               cmd.res_sel = RES_RD;
               state_in    = S_DONE;
            end else begin
               cmd.save_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_FOLLOW;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.res_sel = RES_LERP;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/clit_datapath.sv =====
// ----------------------------------------------------------------------------
// clit_datapath
// Point memory, point counter, scan registers, one multiply per curve and a
// restoring divider lane per curve, plus the result and output registers.
// ----------------------------------------------------------------------------
module clit_datapath
   import clit_pkg::*;
#(
   parameter int MAX_POINTS = CLIT_MAX_POINTS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          st,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [VAL_W-1:0]  req_abscissa,
   input  logic [VAL_W-1:0]  req_water,
   input  logic [VAL_W-1:0]  req_oil,
   output logic [VAL_W-1:0]  out_water,
   output logic [VAL_W-1:0]  out_oil,
   output logic [STAT_W-1:0] out_status
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   entry_type entry_mem [MAX_POINTS];

   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [VAL_W-1:0]     x_ff, x_in;
   entry_type            rd_ff;
   entry_type            prev_ff, prev_in;
   logic [VAL_W-1:0]     wres_ff, wres_in, ores_ff, ores_in;
   logic [STAT_W-1:0]    sres_ff, sres_in;
   logic [VAL_W-1:0]     dx_ff, dx_in, span_ff, span_in;
   logic [VAL_W-1:0]     y0w_ff, y0w_in, dyw_ff, dyw_in;
   logic [VAL_W-1:0]     y0o_ff, y0o_in, dyo_ff, dyo_in;
   logic                 negw_ff, negw_in, nego_ff, nego_in;
   logic [PROD_W-1:0]    accw_ff, accw_in, acco_ff, acco_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [VAL_W-1:0]     outw_ff, outw_in, outo_ff, outo_in;
   logic [STAT_W-1:0]    outs_ff, outs_in;

   logic                 full;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic [CW-1:0]        count_m1;
   logic [AW-1:0]        last_addr;
   logic [AW-1:0]        idx_next;

   // One restoring step: {remainder, dividend low bits} shift left by one,
   // quotient bit enters at the bottom.
   function automatic logic [PROD_W-1:0] div_step_f(input logic [PROD_W-1:0] acc,
                                                     input logic [VAL_W-1:0]  d);
      logic [VAL_W:0] t;
      logic [VAL_W:0] r;
      logic           ge;
      t  = {acc[PROD_W-1:VAL_W], acc[VAL_W-1]};
      ge = (t >= {1'b0, d});
      r  = ge ? (t - {1'b0, d}) : t;
      return {r[VAL_W-1:0], acc[VAL_W-2:0], ge};
   endfunction

   assign full      = (count_ff >= CW'(MAX_POINTS));
   assign wr_en     = cmd.accept && (req_action == ACT_APPEND) && !full;
   assign count_m1  = count_ff - CW'(1);
   assign last_addr = count_m1[AW-1:0];
   assign idx_next  = idx_ff + AW'(1);

   assign st.query_go  = (req_action == ACT_QUERY) && (count_ff != '0);
   assign st.x_le_rd   = (x_ff <= rd_ff.abscissa);
   assign st.x_ge_rd   = (x_ff >= rd_ff.abscissa);
   assign st.in_span   = (x_ff >= prev_ff.abscissa) && (x_ff <= rd_ff.abscissa);
   assign st.zero_span = (prev_ff.abscissa == rd_ff.abscissa);
   assign st.idx_last  = (idx_ff == last_addr);
   assign st.div_last  = (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   assign out_water  = outw_ff;
   assign out_oil    = outo_ff;
   assign out_status = outs_ff;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      x_in     = x_ff;
      prev_in  = prev_ff;
      wres_in  = wres_ff;
      ores_in  = ores_ff;
      sres_in  = sres_ff;
      dx_in    = dx_ff;
      span_in  = span_ff;
      y0w_in   = y0w_ff;
      dyw_in   = dyw_ff;
      negw_in  = negw_ff;
      y0o_in   = y0o_ff;
      dyo_in   = dyo_ff;
      nego_in  = nego_ff;
      accw_in  = accw_ff;
      acco_in  = acco_ff;
      dcnt_in  = dcnt_ff;
      outw_in  = outw_ff;
      outo_in  = outo_ff;
      outs_in  = outs_ff;
      rd_addr  = '0;

      if (cmd.accept) begin
         x_in    = req_abscissa;
         wres_in = '0;
         ores_in = '0;
         sres_in = STAT_OK;
         case (req_action)
            ACT_CLEAR: begin
               count_in = '0;
            end
            ACT_APPEND: begin
               if (full) begin
                  sres_in = STAT_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            ACT_QUERY: begin
               if (count_ff == '0) begin
                  sres_in = STAT_EMPTY;
               end
            end
            default: begin
               sres_in = STAT_OK;
            end
         endcase
      end

      if (cmd.rd_en) begin
         case (cmd.rd_sel)
            RD_HEAD:   rd_addr = '0;
            RD_TAIL:   rd_addr = last_addr;
            RD_SECOND: begin
               rd_addr = AW'(1);
               idx_in  = AW'(1);
            end
            RD_FOLLOW: begin
               rd_addr = idx_next;
               idx_in  = idx_next;
            end
            default:   rd_addr = '0;
         endcase
      end

      if (cmd.save_prev) begin
         prev_in = rd_ff;
      end

      if (cmd.start_interp) begin
         dx_in   = x_ff - prev_ff.abscissa;
         span_in = rd_ff.abscissa - prev_ff.abscissa;
         y0w_in  = prev_ff.water;
         negw_in = (rd_ff.water < prev_ff.water);
         dyw_in  = negw_in ? (prev_ff.water - rd_ff.water) : (rd_ff.water - prev_ff.water);
         y0o_in  = prev_ff.oil;
         nego_in = (rd_ff.oil < prev_ff.oil);
         dyo_in  = nego_in ? (prev_ff.oil - rd_ff.oil) : (rd_ff.oil - prev_ff.oil);
      end

      // dx <= span, so the quotient fits in VAL_W bits and the top half of
      // the product already sits below the divisor
      if (cmd.mul) begin
         accw_in = PROD_W'(dx_ff) * PROD_W'(dyw_ff);
         acco_in = PROD_W'(dx_ff) * PROD_W'(dyo_ff);
         dcnt_in = '0;
      end

      if (cmd.div_step) begin
         accw_in = div_step_f(accw_ff, span_ff);
         acco_in = div_step_f(acco_ff, span_ff);
         dcnt_in = dcnt_ff + DIV_CNT_W'(1);
      end

      case (cmd.res_sel)
         RES_PREV: begin
            wres_in = prev_ff.water;
            ores_in = prev_ff.oil;
         end
         RES_RD: begin
            wres_in = rd_ff.water;
            ores_in = rd_ff.oil;
         end
         RES_LERP: begin
            wres_in = negw_ff ? (y0w_ff - accw_ff[VAL_W-1:0])
                              : (y0w_ff + accw_ff[VAL_W-1:0]);
            ores_in = nego_ff ? (y0o_ff - acco_ff[VAL_W-1:0])
                              : (y0o_ff + acco_ff[VAL_W-1:0]);
         end
         default: begin
         end
      endcase

      if (cmd.load_out) begin
         outw_in = wres_ff;
         outo_in = ores_ff;
         outs_in = sres_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[count_ff[AW-1:0]] <= '{abscissa: req_abscissa,
                                         water:    req_water,
                                         oil:      req_oil};
      end
      if (cmd.rd_en) begin
         rd_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      prev_ff <= prev_in;
      wres_ff <= wres_in;
      ores_ff <= ores_in;
      sres_ff <= sres_in;
      dx_ff   <= dx_in;
      span_ff <= span_in;
      y0w_ff  <= y0w_in;
      dyw_ff  <= dyw_in;
      negw_ff <= negw_in;
      y0o_ff  <= y0o_in;
      dyo_ff  <= dyo_in;
      nego_ff <= nego_in;
      accw_ff <= accw_in;
      acco_ff <= acco_in;
      dcnt_ff <= dcnt_in;
      outw_ff <= outw_in;
      outo_ff <= outo_in;
      outs_ff <= outs_in;
   end

endmodule

// ===== rtl/core/clamped_linear_interp_table.sv =====
// ----------------------------------------------------------------------------
// clamped_linear_interp_table
// Two-curve piecewise-linear lookup table with clamping at both ends.
// ----------------------------------------------------------------------------
// Every request word gives exactly one response word. A clear, an append or a
// query on an empty table goes straight to the done state after
// acceptance. A query clamps at the first point if the abscissa is at or
// below it, else at the last point if at or above it; otherwise it walks up
// to MAX_POINTS-1 stored intervals, the matching one included, and takes the
// left point of a zero-width interval, the last point if no interval matches,
// or else interpolates: the walk reads the single-port point memory one entry
// a cycle, then a multiply and a 17-step restoring divide (both curves in
// parallel) follow. The next request is taken the cycle after a response is
// loaded into the output register. One word is in flight at a time; a
// finished response may wait in the output register while the next request
// is taken. Stored points need no clearing pass after reset.
`include "clamped_linear_interp_table_macros.svh"

module clamped_linear_interp_table
   import clit_pkg::*;
#(
   parameter int MAX_POINTS = CLIT_MAX_POINTS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request: abscissa [16:0], water_value [33:17], oil_value [50:34]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // request: action [1:0]
   input  logic [ACT_W-1:0]       req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // response: water_result [16:0], oil_result [33:17]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // response: status [1:0]
   output logic [STAT_W-1:0]      rsp_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready
);

   cmd_type          cmd;
   stat_type         st;
   logic [VAL_W-1:0] out_water;
   logic [VAL_W-1:0] out_oil;

   clit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   clit_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_action   (req_tuser),
      .req_abscissa (req_tdata[VAL_W-1:0]),
      .req_water    (req_tdata[2*VAL_W-1:VAL_W]),
      .req_oil      (req_tdata[3*VAL_W-1:2*VAL_W]),
      .out_water    (out_water),
      .out_oil      (out_oil),
      .out_status   (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - 2 * VAL_W){1'b0}}, out_oil, out_water};

   `CLIT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while previous word still in work")
   `CLIT_ASSERT_IMP(a_error_zero_data, clock, reset, rsp_tvalid && (rsp_tuser != STAT_OK), rsp_tdata == '0, "non-ok response carries data")
   `CLIT_ASSERT_NXT(a_mul_then_div, clock, reset, cmd.mul, cmd.div_step, "divide did not follow multiply")
   `CLIT_ASSERT_IMP(a_load_when_busy, clock, reset, cmd.load_out, !req_tready, "output loaded while idle")

endmodule
